// ===== design/cld_pkg.sv =====
// ============================================================================
// cld_pkg: shared types and constants for the Content-Length deframer
// Frame text tables, phase and result codes, and the result record.
// ============================================================================
package cld_pkg;

    // Width of the length accumulator and body counter
    localparam int LENGTH_BITS = 17;
    // Width of the max_length register (fixed by the register map)
    localparam int MAXLEN_BITS = 17;
    // Compare width for length against max_length
    localparam int CMP_BITS    = (LENGTH_BITS > MAXLEN_BITS) ? LENGTH_BITS : MAXLEN_BITS;
    // Width of accum * 10 + digit before saturation
    localparam int MAC_BITS    = LENGTH_BITS + 4;

    localparam logic [LENGTH_BITS-1:0] LEN_LIMIT     = '1;
    localparam logic [MAXLEN_BITS-1:0] MAXLEN_RESET  = MAXLEN_BITS'(65536);

    localparam logic [7:0] CHAR_0  = 8'h30;
    localparam logic [7:0] CHAR_9  = 8'h39;
    localparam logic [7:0] CHAR_CR = 8'h0D;
    localparam logic [7:0] CHAR_LF = 8'h0A;

    // "Content-Length: "
    localparam logic [7:0] HDR_TEXT [16] = '{
        8'h43, 8'h6F, 8'h6E, 8'h74, 8'h65, 8'h6E, 8'h74, 8'h2D,
        8'h4C, 8'h65, 8'h6E, 8'h67, 8'h74, 8'h68, 8'h3A, 8'h20
    };

    // CR LF CR LF
    localparam logic [7:0] TERM_TEXT [4] = '{CHAR_CR, CHAR_LF, CHAR_CR, CHAR_LF};

    typedef enum logic [1:0] {
        PH_PREFIX = 2'd0,
        PH_DIGITS = 2'd1,
        PH_TERM   = 2'd2,
        PH_BODY   = 2'd3
    } t_phase;

    typedef enum logic [1:0] {
        KIND_BODY  = 2'd0,
        KIND_EMPTY = 2'd1,
        KIND_ERROR = 2'd2
    } t_kind;

    typedef enum logic [1:0] {
        ERR_PREFIX = 2'd0,
        ERR_TERM   = 2'd1,
        ERR_LONG   = 2'd2
    } t_err;

    typedef struct packed {
        logic       valid;
        t_kind      kind;
        logic [7:0] body_byte;
        logic       last;
        t_err       error_code;
    } t_result;

endpackage

// ===== design/cld_if.sv =====
// ============================================================================
// cld_if: channel interfaces of the Content-Length deframer
// Byte input, result output and max_length write channels.
// ============================================================================
interface cld_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

interface cld_out_if;
    logic       valid;
    logic       ready;
    logic [1:0] kind;
    logic [7:0] body_byte;
    logic       last;
    logic [1:0] error_code;

    modport source (output valid, output kind, output body_byte, output last,
                    output error_code, input ready);
    modport sink   (input valid, input kind, input body_byte, input last,
                    input error_code, output ready);
endinterface

interface cld_cfg_if;
    logic        valid;
    logic        ready;
    logic [16:0] max_length;

    modport source (output valid, output max_length, input ready);
    modport sink   (input valid, input max_length, output ready);
endinterface

// ===== design/cld_in_stage.sv =====
// ============================================================================
// cld_in_stage: input byte register
// Holds one received beat until the parser consumes it.
// ============================================================================
module cld_in_stage
    import cld_pkg::*;
(
    input  logic         i_clk,
    input  logic         i_rst_n,
    cld_in_if.sink       i_rx,
    input  logic         i_take,     // parser consumes the held byte
    output logic         o_valid,
    output logic [7:0]   o_byte
);

    logic       r_valid;
    logic [7:0] r_byte;
    logic       accept;

    assign i_rx.ready = !r_valid || i_take;
    assign accept     = i_rx.valid && i_rx.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (accept) begin
            r_valid <= 1'b1;
        end else if (i_take) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_byte <= i_rx.rx_byte;
        end
    end

    assign o_valid = r_valid;
    assign o_byte  = r_byte;

endmodule

// ===== design/cld_parse.sv =====
// ============================================================================
// cld_parse: frame parser
// Per-byte phase machine: prefix compare, digit accumulate, terminator
// check, body pass-through. Also holds the max_length register.
// ============================================================================
module cld_parse
    import cld_pkg::*;
(
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_step,      // consume i_byte this cycle
    input  logic [7:0]             i_byte,
    input  logic                   i_cfg_we,
    input  logic [MAXLEN_BITS-1:0] i_cfg_data,
    output t_result                o_res
);

    t_phase                 r_phase,  n_phase;
    logic [3:0]             r_pos,    n_pos;
    logic                   r_mis,    n_mis;
    logic [LENGTH_BITS-1:0] r_accum,  n_accum;
    logic [LENGTH_BITS-1:0] r_left,   n_left;
    logic [MAXLEN_BITS-1:0] r_max_length;

    logic                   hdr_miss;
    logic                   term_miss;
    logic                   is_digit;
    logic [3:0]             digit;
    logic [MAC_BITS-1:0]    mac;
    logic [LENGTH_BITS-1:0] accum_sat;
    logic                   prefix_bad;
    logic                   term_bad;
    logic                   too_long;
    logic                   len_zero;
    logic                   left_last;

    // Per-byte decode
    assign hdr_miss   = (i_byte != HDR_TEXT[r_pos]);
    assign term_miss  = (i_byte != TERM_TEXT[r_pos[1:0]]);
    assign is_digit   = (i_byte >= CHAR_0) && (i_byte <= CHAR_9);
    assign digit      = 4'(i_byte - CHAR_0);
    assign mac        = (MAC_BITS'(r_accum) << 3) + (MAC_BITS'(r_accum) << 1)
                      + MAC_BITS'(digit);
    assign accum_sat  = (mac > MAC_BITS'(LEN_LIMIT)) ? LEN_LIMIT : mac[LENGTH_BITS-1:0];
    assign prefix_bad = r_mis || hdr_miss;
    assign term_bad   = r_mis || term_miss;
    assign too_long   = CMP_BITS'(r_accum) > CMP_BITS'(r_max_length);
    assign len_zero   = (r_accum == '0);
    assign left_last  = (r_left <= LENGTH_BITS'(1));

    // Next state
    always_comb begin
        n_phase = r_phase;
        n_pos   = r_pos;
        n_mis   = r_mis;
        n_accum = r_accum;
        n_left  = r_left;
        case (r_phase)
            PH_PREFIX: begin
                n_mis = prefix_bad;
                n_pos = r_pos + 4'd1;
                if (r_pos == 4'd15) begin
                    n_pos   = '0;
                    n_accum = '0;
                    if (prefix_bad) begin
                        n_mis  = 1'b0;
                        n_left = '0;
                    end else begin
                        n_phase = PH_DIGITS;
                    end
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    n_accum = accum_sat;
                end else begin
                    n_phase = PH_TERM;
                    n_mis   = (i_byte != CHAR_CR);
                    n_pos   = 4'd1;
                end
            end
            PH_TERM: begin
                n_mis = term_bad;
                n_pos = r_pos + 4'd1;
                if (r_pos[1:0] == 2'd3) begin
                    n_pos = '0;
                    n_mis = 1'b0;
                    if (term_bad || too_long || len_zero) begin
                        n_phase = PH_PREFIX;
                        n_accum = '0;
                        n_left  = '0;
                    end else begin
                        n_phase = PH_BODY;
                        n_left  = r_accum;
                    end
                end
            end
            PH_BODY: begin
                if (left_last) begin
                    n_phase = PH_PREFIX;
                    n_pos   = '0;
                    n_mis   = 1'b0;
                    n_accum = '0;
                    n_left  = '0;
                end else begin
                    n_left = r_left - LENGTH_BITS'(1);
                end
            end
            default: begin
                n_phase = PH_PREFIX;
            end
        endcase
    end

    // Result for the current byte
    always_comb begin
        o_res = '{valid: 1'b0, kind: KIND_BODY, body_byte: 8'h00, last: 1'b0,
                  error_code: ERR_PREFIX};
        case (r_phase)
            PH_PREFIX: begin
                if (r_pos == 4'd15 && prefix_bad) begin
                    o_res.valid      = 1'b1;
                    o_res.kind       = KIND_ERROR;
                    o_res.error_code = ERR_PREFIX;
                end
            end
            PH_TERM: begin
                if (r_pos[1:0] == 2'd3) begin
                    if (term_bad) begin
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_TERM;
                    end else if (too_long) begin
                        o_res.valid      = 1'b1;
                        o_res.kind       = KIND_ERROR;
                        o_res.error_code = ERR_LONG;
                    end else if (len_zero) begin
                        o_res.valid = 1'b1;
                        o_res.kind  = KIND_EMPTY;
                    end
                end
            end
            PH_BODY: begin
                o_res.valid     = 1'b1;
                o_res.kind      = KIND_BODY;
                o_res.body_byte = i_byte;
                o_res.last      = left_last;
            end
            default: begin
                o_res.valid = 1'b0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_PREFIX;
            r_pos   <= '0;
            r_mis   <= 1'b0;
            r_accum <= '0;
            r_left  <= '0;
        end else if (i_step) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_mis   <= n_mis;
            r_accum <= n_accum;
            r_left  <= n_left;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_length <= MAXLEN_RESET;
        end else if (i_cfg_we) begin
            r_max_length <= i_cfg_data;
        end
    end

endmodule

// ===== design/cld_out_stage.sv =====
// ============================================================================
// cld_out_stage: result register
// Holds one result beat until the receiver takes it.
// ============================================================================
module cld_out_stage
    import cld_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_load,     // parser step this cycle
    input  t_result     i_res,
    output logic        o_free,     // register can take a new result
    cld_out_if.source   o_res
);

    logic    r_valid;
    t_result r_res;

    assign o_free = !r_valid || o_res.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load && i_res.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_free && i_load) begin
            r_res <= i_res;
        end
    end

    assign o_res.valid      = r_valid;
    assign o_res.kind       = r_res.kind;
    assign o_res.body_byte  = r_res.body_byte;
    assign o_res.last       = r_res.last;
    assign o_res.error_code = r_res.error_code;

endmodule

// ===== design/content_length_deframer.sv =====
// ============================================================================
// content_length_deframer: Content-Length framed byte stream receiver
// Strips "Content-Length: <n>\r\n\r\n" headers and forwards body bytes.
// ============================================================================
// Usage
//   i_rx  : one received byte per beat (valid/ready).
//   o_res : one result beat per body byte (kind 0, last on the final byte),
//           one kind 1 beat for an empty body, one kind 2 beat with an
//           error code for a bad prefix, bad terminator or too-long length.
//           Header bytes that complete nothing give no beat.
//   i_cfg : writes max_length; always ready. Write it only while idle.
// Path: a byte accepted at i_rx is held in the input register, decoded by the
//   combinational parser, then registered in the result register for o_res.
// Throughput: one byte per cycle while o_res is not held off; the parser is
//   combinational and both registers refill in the cycle they empty.
// Stall: when o_res is held off, the result register stays full, the parser
//   waits, and i_rx ready stays low while the input register holds a byte.
// Reset: synchronous active-low; the parser goes back to prefix hunting,
//   both registers empty, and max_length returns to 65536.
// ============================================================================
module content_length_deframer
    import cld_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    cld_in_if.sink     i_rx,
    cld_out_if.source  o_res,
    cld_cfg_if.sink    i_cfg
);

    logic       in_valid;
    logic [7:0] in_byte;
    logic       out_free;
    logic       step;
    t_result    res;

    // Parser advances when a byte is held and the result register has room
    assign step = in_valid && out_free;

    // Config channel never back-pressures
    assign i_cfg.ready = 1'b1;

    cld_in_stage u_in_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rx    (i_rx),
        .i_take  (step),
        .o_valid (in_valid),
        .o_byte  (in_byte)
    );

    cld_parse u_parse (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_step     (step),
        .i_byte     (in_byte),
        .i_cfg_we   (i_cfg.valid),
        .i_cfg_data (i_cfg.max_length),
        .o_res      (res)
    );

    cld_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (step),
        .i_res   (res),
        .o_free  (out_free),
        .o_res   (o_res)
    );

endmodule
